FILE: rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg - shared types and constants of the frame reassembly ring
// Field layout of the stream beats, slot geometry and the work entry that
// travels from the classifier to the store engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int FRAME_BYTES = 65536;
   localparam int OFFSET_W    = $clog2(FRAME_BYTES);
   localparam int ADDR_W      = SLOT_W + OFFSET_W;
   localparam int STORE_DEPTH = NUM_SLOTS * FRAME_BYTES;
   localparam int MAX_PAYLOAD = 1024;

   localparam int PAYLOAD_W = 11;
   localparam int RING_W    = 3;
   localparam int FRAME_W   = 16;
   localparam int PKT_W     = 13;
   localparam int INDEX_W   = 10;
   localparam int BYTE_W    = 8;
   localparam int RSLOT_W   = 2;
   localparam int ROFF_W    = 16;
   localparam int SIZE_W    = 17;
   localparam int PROD_W    = PAYLOAD_W + PKT_W;
   localparam int OFF_W     = PROD_W + 1;

   // request tdata layout, lowest field first
   localparam int FRAME_LSB  = 0;
   localparam int PKT_LSB    = FRAME_LSB + FRAME_W;
   localparam int INDEX_LSB  = PKT_LSB + PKT_W;
   localparam int DATA_LSB   = INDEX_LSB + INDEX_W;
   localparam int RSLOT_LSB  = DATA_LSB + BYTE_W;
   localparam int ROFF_LSB   = RSLOT_LSB + RSLOT_W;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;

   // response tdata layout, lowest field first
   localparam int RSP_SLOT_LSB = 0;
   localparam int RSP_SIZE_LSB = RSP_SLOT_LSB + RSLOT_W;
   localparam int RSP_TAG_LSB  = RSP_SIZE_LSB + SIZE_W;
   localparam int RSP_BYTE_LSB = RSP_TAG_LSB + FRAME_W;
   localparam int RSP_DATA_W   = 48;
   localparam int RSP_USER_W   = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_READY  = 2'd0,
      KIND_DROP   = 2'd1,
      KIND_READ   = 2'd2,
      KIND_BEYOND = 2'd3
   } rsp_kind_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_DROP   = 2'd2,
      OP_BEYOND = 2'd3
   } op_act_type;

   typedef enum logic {
      FUNC_STORE = 1'b0,
      FUNC_READ  = 1'b1
   } req_func_type;

   // one classified beat; rdy carries an optional frame-ready report ahead of act
   typedef struct packed {
      logic                rdy;
      logic [SLOT_W-1:0]   rdy_slot;
      logic [SIZE_W-1:0]   rdy_size;
      logic [FRAME_W-1:0]  rdy_tag;
      op_act_type          act;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_W-1:0]   size;
      logic [FRAME_W-1:0]  tag;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } fra_op_type;

endpackage

`default_nettype wire

FILE: rtl/fra_front.sv
// ----------------------------------------------------------------------------
// fra_front - request intake and slot classifier
// Registers each request beat with its packet offset product, then matches
// the frame against the slot tags, allocates ring slots and tracks lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fra_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [fra_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic [fra_pkg::PAYLOAD_W-1:0]    payload_size,
   input  logic [fra_pkg::RING_W-1:0]       slots_in_use,
   input  logic                             q_full,
   output logic                             q_push,
   output fra_pkg::fra_op_type              q_op
);
   import fra_pkg::*;

   function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] cur,
                                                   input logic [RING_W-1:0] len);
      logic [RING_W-1:0] r;
      r = RING_W'(cur) + RING_W'(1);
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (r >= len) r = r - len;
      end
      return r[SLOT_W-1:0];
   endfunction

   // intake stage
   logic                 p_valid_ff, p_valid_in;
   req_func_type         p_func_ff;
   logic                 p_first_ff;
   logic [FRAME_W-1:0]   p_frame_ff;
   logic                 p_pkt_zero_ff;
   logic [PROD_W-1:0]    p_prod_ff;
   logic [INDEX_W-1:0]   p_index_ff;
   logic [BYTE_W-1:0]    p_data_ff;
   logic [RSLOT_W-1:0]   p_rslot_ff;
   logic [ROFF_W-1:0]    p_roff_ff;

   logic                 req_fire;
   logic                 p_go;
   logic [PAYLOAD_W-1:0] eff_pay;
   logic [RING_W-1:0]    ring_len;
   logic [PKT_W-1:0]     in_pkt;
   logic [PROD_W-1:0]    prod_in;

   // slot state
   logic [FRAME_W-1:0]   tag_ff [NUM_SLOTS];
   logic [FRAME_W-1:0]   tag_in [NUM_SLOTS];
   logic [SIZE_W-1:0]    len_ff [NUM_SLOTS];
   logic [SIZE_W-1:0]    len_in [NUM_SLOTS];
   logic [FRAME_W-1:0]   newest_frame_ff, newest_frame_in;
   logic [SLOT_W-1:0]    newest_slot_ff, newest_slot_in;
   logic [SLOT_W-1:0]    cur_slot_ff, cur_slot_in;
   logic                 cur_acc_ff, cur_acc_in;

   logic [OFF_W-1:0]     off_sum;
   logic                 bad;
   logic [OFFSET_W-1:0]  off;
   logic [SIZE_W-1:0]    byte_end;
   logic                 found;
   logic [SLOT_W-1:0]    pos;
   logic                 newer;
   logic                 alloc;
   logic [SLOT_W-1:0]    next_slot;
   logic                 acc;
   logic [SLOT_W-1:0]    sel_slot;
   logic [SIZE_W-1:0]    sel_len;
   logic [FRAME_W-1:0]   sel_tag;
   logic [SIZE_W-1:0]    base_len;
   logic [FRAME_W-1:0]   base_tag;

   assign p_go       = p_valid_ff && !q_full;
   assign req_tready = !p_valid_ff || !q_full;
   assign req_fire   = req_tvalid && req_tready;
   assign in_pkt     = req_tdata[PKT_LSB +: PKT_W];

   always_comb begin
      if (payload_size == '0) eff_pay = PAYLOAD_W'(1);
      else if (payload_size > PAYLOAD_W'(MAX_PAYLOAD)) eff_pay = PAYLOAD_W'(MAX_PAYLOAD);
      else eff_pay = payload_size;

      if (slots_in_use == '0) ring_len = RING_W'(1);
      else if (slots_in_use > RING_W'(NUM_SLOTS)) ring_len = RING_W'(NUM_SLOTS);
      else ring_len = slots_in_use;

      prod_in = PROD_W'(eff_pay) * PROD_W'(in_pkt - PKT_W'(1));

      if (req_fire) p_valid_in = 1'b1;
      else if (p_go) p_valid_in = 1'b0;
      else p_valid_in = p_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_func_ff     <= req_func_type'(req_tuser[0]);
         p_first_ff    <= req_tuser[1];
         p_frame_ff    <= req_tdata[FRAME_LSB +: FRAME_W];
         p_pkt_zero_ff <= (in_pkt == '0);
         p_prod_ff     <= prod_in;
         p_index_ff    <= req_tdata[INDEX_LSB +: INDEX_W];
         p_data_ff     <= req_tdata[DATA_LSB +: BYTE_W];
         p_rslot_ff    <= req_tdata[RSLOT_LSB +: RSLOT_W];
         p_roff_ff     <= req_tdata[ROFF_LSB +: ROFF_W];
      end
   end

   // classification
   always_comb begin
      off_sum  = OFF_W'(p_prod_ff) + OFF_W'(p_index_ff);
      bad      = p_pkt_zero_ff || (off_sum >= OFF_W'(FRAME_BYTES));
      off      = off_sum[OFFSET_W-1:0];
      byte_end = SIZE_W'(off) + SIZE_W'(1);

      // highest matching slot wins
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ((RING_W'(i) < ring_len) && (tag_ff[i] == p_frame_ff)) begin
            found = 1'b1;
            pos   = SLOT_W'(i);
         end
      end

      newer = (p_frame_ff > newest_frame_ff) ||
              ((p_frame_ff == FRAME_W'(1)) && (newest_frame_ff != FRAME_W'(1)));
      alloc     = p_first_ff && !found && newer;
      next_slot = ring_next(newest_slot_ff, ring_len);
      acc       = p_first_ff ? (found || alloc) : cur_acc_ff;

      if (p_func_ff == FUNC_READ) sel_slot = SLOT_W'(p_rslot_ff);
      else if (alloc) sel_slot = next_slot;
      else if (p_first_ff) sel_slot = pos;
      else sel_slot = cur_slot_ff;

      sel_len  = len_ff[sel_slot];
      sel_tag  = tag_ff[sel_slot];
      base_len = alloc ? '0 : sel_len;
      base_tag = alloc ? p_frame_ff : sel_tag;
   end

   always_comb begin
      q_push          = 1'b0;
      q_op            = '0;
      q_op.act        = OP_WRITE;
      tag_in          = tag_ff;
      len_in          = len_ff;
      newest_frame_in = newest_frame_ff;
      newest_slot_in  = newest_slot_ff;
      cur_slot_in     = cur_slot_ff;
      cur_acc_in      = cur_acc_ff;

      if (p_go) begin
         if (p_func_ff == FUNC_READ) begin
            q_push    = 1'b1;
            q_op.act  = OP_READ;
            q_op.slot = sel_slot;
            q_op.size = sel_len;
            q_op.tag  = sel_tag;
            q_op.addr = {sel_slot, OFFSET_W'(p_roff_ff)};
         end else begin
            if (p_first_ff) begin
               if (alloc) begin
                  newest_frame_in   = p_frame_ff;
                  newest_slot_in    = next_slot;
                  tag_in[next_slot] = p_frame_ff;
                  len_in[next_slot] = '0;
                  // slot being reused still holds a frame: report it first
                  if (sel_len != '0) begin
                     q_op.rdy      = 1'b1;
                     q_op.rdy_slot = next_slot;
                     q_op.rdy_size = sel_len;
                     q_op.rdy_tag  = sel_tag;
                  end
               end
               cur_acc_in = found || alloc;
               if (found || alloc) begin
                  cur_slot_in = sel_slot;
               end else begin
                  q_push   = 1'b1;
                  q_op.act = OP_DROP;
               end
            end
            if (acc) begin
               q_push = 1'b1;
               if (bad) begin
                  q_op.act  = OP_BEYOND;
                  q_op.slot = sel_slot;
                  q_op.size = base_len;
                  q_op.tag  = base_tag;
               end else begin
                  q_op.act  = OP_WRITE;
                  q_op.addr = {sel_slot, off};
                  q_op.data = p_data_ff;
                  if (byte_end > base_len) len_in[sel_slot] = byte_end;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_ff[i] <= '0;
            len_ff[i] <= '0;
         end
         newest_frame_ff <= '0;
         newest_slot_ff  <= '0;
         cur_slot_ff     <= '0;
         cur_acc_ff      <= 1'b0;
      end else begin
         tag_ff          <= tag_in;
         len_ff          <= len_in;
         newest_frame_ff <= newest_frame_in;
         newest_slot_ff  <= newest_slot_in;
         cur_slot_ff     <= cur_slot_in;
         cur_acc_ff      <= cur_acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fra_queue.sv
// ----------------------------------------------------------------------------
// fra_queue - work queue between classifier and store engine
// Small register FIFO of classified beats; lets either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fra_pkg::fra_op_type  push_op,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output fra_pkg::fra_op_type  head_op
);
   import fra_pkg::*;

   fra_op_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

`default_nettype wire

FILE: rtl/fra_back.sv
// ----------------------------------------------------------------------------
// fra_back - frame store engine and response register
// Writes and reads the slot byte store and emits up to two response beats
// per queue entry through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  fra_pkg::fra_op_type              head_op,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [fra_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);
   import fra_pkg::*;

   logic [BYTE_W-1:0]    store_mem [STORE_DEPTH];

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_kind_type         rsp_kind_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [SIZE_W-1:0]    rsp_size_ff;
   logic [FRAME_W-1:0]   rsp_tag_ff;
   logic                 rsp_last_ff;
   logic [BYTE_W-1:0]    rd_byte_ff;
   logic                 rdy_done_ff, rdy_done_in;

   logic                 out_free;
   logic                 has_second;
   logic                 rdy_pend;
   logic                 emit;
   rsp_kind_type         e_kind;
   rsp_kind_type         act_kind;
   logic [SLOT_W-1:0]    e_slot;
   logic [SIZE_W-1:0]    e_size;
   logic [FRAME_W-1:0]   e_tag;
   logic                 e_last;
   logic                 wr_en;
   logic                 rd_en;
   logic [BYTE_W-1:0]    rd_val;

   always_comb begin
      unique case (head_op.act)
         OP_READ:   act_kind = KIND_READ;
         OP_DROP:   act_kind = KIND_DROP;
         OP_BEYOND: act_kind = KIND_BEYOND;
         OP_WRITE:  act_kind = KIND_READY;
      endcase
   end

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      has_second  = (head_op.act != OP_WRITE);
      rdy_pend    = head_valid && head_op.rdy && !rdy_done_ff;
      emit        = 1'b0;
      pop         = 1'b0;
      e_kind      = KIND_READY;
      e_slot      = '0;
      e_size      = '0;
      e_tag       = '0;
      e_last      = 1'b0;
      rdy_done_in = rdy_done_ff;

      if (rdy_pend) begin
         emit   = out_free;
         e_slot = head_op.rdy_slot;
         e_size = head_op.rdy_size;
         e_tag  = head_op.rdy_tag;
         e_last = !has_second;
         pop    = out_free && !has_second;
         rdy_done_in = out_free && has_second;
      end else if (head_valid) begin
         if (has_second) begin
            emit   = out_free;
            pop    = out_free;
            e_kind = act_kind;
            e_slot = head_op.slot;
            e_size = head_op.size;
            e_tag  = head_op.tag;
            e_last = 1'b1;
         end else begin
            pop = 1'b1;
         end
         if (pop) rdy_done_in = 1'b0;
      end

      wr_en = pop && (head_op.act == OP_WRITE);
      rd_en = emit && !rdy_pend && (head_op.act == OP_READ);

      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rdy_done_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rdy_done_ff  <= rdy_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_slot_ff <= e_slot;
         rsp_size_ff <= e_size;
         rsp_tag_ff  <= e_tag;
         rsp_last_ff <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[head_op.addr] <= head_op.data;
      if (rd_en) rd_byte_ff <= store_mem[head_op.addr];
   end

   assign rd_val     = (rsp_kind_ff == KIND_READ) ? rd_byte_ff : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rd_val, rsp_tag_ff, rsp_size_ff,
                                    RSLOT_W'(rsp_slot_ff)});
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/frame_reassembly_ring.sv
// ----------------------------------------------------------------------------
// frame_reassembly_ring - packet to frame reassembly into a ring of slots
// Stores packet bytes at their frame offset, allocates ring slots for new
// frames, reports finished frames and serves byte reads from the store.
// ----------------------------------------------------------------------------
//  channel | dir | beat content
//  req_    | in  | tdata: frame, packet, index, byte, read slot/offset; tuser: func, first
//  rsp_    | out | tdata: slot, size, tag, read byte; tuser: kind; tlast: end of run
//  csr_    | in  | 0x0 payload_size, 0x4 slots_in_use
//
//  One request beat per cycle while the work queue is not full; a beat that reports
//  a finished frame as well as its own result emits two response beats.
//  A response passes the intake register with offset multiply, the four-entry
//  work queue and the response register.
//  Reset clears slot tags and lengths; the byte store is not cleared.
//  Stalls on rsp_ back up through the work queue to req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_reassembly_ring (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // frame_number, packet_number, byte_index, data_byte, read_slot, read_offset
   input  logic [fra_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func, first_byte
   input  logic [fra_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // slot, frame_size, frame_tag, read_byte
   output logic [fra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic [fra_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fra_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fra_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fra_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import fra_pkg::*;

   localparam logic REG_PAYLOAD_SIZE = 1'b0;
   localparam logic REG_SLOTS_IN_USE = 1'b1;

   logic [PAYLOAD_W-1:0] payload_size_ff;
   logic [RING_W-1:0]    slots_in_use_ff;
   logic                 csr_wr;
   logic                 csr_index;

   logic                 q_push;
   fra_op_type           q_op;
   logic                 q_full;
   logic                 q_pop;
   logic                 head_valid;
   fra_op_type           head_op;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_size_ff <= PAYLOAD_W'(MAX_PAYLOAD);
         slots_in_use_ff <= RING_W'(NUM_SLOTS);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_PAYLOAD_SIZE: payload_size_ff <= csr_pwdata[PAYLOAD_W-1:0];
            REG_SLOTS_IN_USE: slots_in_use_ff <= csr_pwdata[RING_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PAYLOAD_SIZE: csr_prdata = CSR_DATA_W'(payload_size_ff);
         REG_SLOTS_IN_USE: csr_prdata = CSR_DATA_W'(slots_in_use_ff);
      endcase
   end

   fra_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .payload_size (payload_size_ff),
      .slots_in_use (slots_in_use_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_op         (q_op)
   );

   fra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   fra_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker - port-level checks for the frame reassembly ring
// Watches the response channel for stall hold, run ends and field content.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [fra_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [fra_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             rsp_tlast
);
   import fra_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // only a frame-ready report can be followed by another beat of the same run
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_READY) |-> rsp_tlast)
      else $error("non frame-ready beat without tlast");

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DROP) |-> (rsp_tdata == '0))
      else $error("drop beat carries slot data");

   a_ready_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_READY) |->
         (rsp_tdata[RSP_SIZE_LSB +: SIZE_W] != '0) &&
         (rsp_tdata[RSP_BYTE_LSB +: BYTE_W] == '0))
      else $error("frame-ready beat with empty frame or stray byte");

endmodule

bind frame_reassembly_ring fra_checker u_fra_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for frame_reassembly_ring
// Drives request beats and CSR writes, predicts every response beat with a
// behavioural copy of the slot ring and byte store, and compares each
// response field by field. Covers corner cases, register limits, a long
// response stall and random packet traffic under several idle patterns.
// ----------------------------------------------------------------------------
module testbench;
   import fra_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_PAYLOAD = 3'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOTS   = 3'h4;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_PRINTED   = 50;

   typedef struct {
      req_func_type       func;
      logic [FRAME_W-1:0] frame;
      logic [PKT_W-1:0]   pkt;
      logic [INDEX_W-1:0] idx;
      logic               first;
      logic [BYTE_W-1:0]  data;
      logic [RSLOT_W-1:0] rslot;
      logic [ROFF_W-1:0]  roff;
   } req_beat_type;

   typedef struct {
      rsp_kind_type       kind;
      logic [RSLOT_W-1:0] slot;
      logic [SIZE_W-1:0]  size;
      logic [FRAME_W-1:0] tag;
      logic [BYTE_W-1:0]  rbyte;
      logic               last;
   } rsp_beat_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ring state as the block should hold it
   logic [PAYLOAD_W-1:0] payload_cfg = 11'd1024;
   logic [RING_W-1:0]    ring_cfg    = 3'd4;
   logic [FRAME_W-1:0]   slot_frame [NUM_SLOTS] = '{default: '0};
   logic [SIZE_W-1:0]    slot_fill  [NUM_SLOTS] = '{default: '0};
   logic [FRAME_W-1:0]   newest_frame_no = '0;
   logic [SLOT_W-1:0]    newest_slot_no  = '0;
   logic [SLOT_W-1:0]    open_slot       = '0;
   bit                   open_accepted   = 1'b0;
   logic [BYTE_W-1:0]    byte_mirror [int unsigned];
   int unsigned          written_addrs [$];
   rsp_beat_type         rsp_due [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned mismatch_count = 0;

   frame_reassembly_ring dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("[frame_reassembly_ring] ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int unsigned ring_len();
      if (ring_cfg == 0) return 1;
      if (ring_cfg > NUM_SLOTS) return NUM_SLOTS;
      return 32'(ring_cfg);
   endfunction

   function automatic int unsigned payload_len();
      if (payload_cfg == 0) return 1;
      if (payload_cfg > MAX_PAYLOAD) return MAX_PAYLOAD;
      return 32'(payload_cfg);
   endfunction

   function automatic rsp_beat_type make_rsp(input rsp_kind_type kind,
                                             input logic [RSLOT_W-1:0] slot,
                                             input logic [SIZE_W-1:0] size,
                                             input logic [FRAME_W-1:0] tag,
                                             input logic [BYTE_W-1:0] rbyte,
                                             input logic last);
      rsp_beat_type r;
      r.kind  = kind;
      r.slot  = slot;
      r.size  = size;
      r.tag   = tag;
      r.rbyte = rbyte;
      r.last  = last;
      return r;
   endfunction

   // applies one accepted beat to the ring; returns 0 when the block ignores it
   function automatic bit reassemble_beat(input req_beat_type b);
      rsp_beat_type      ready_rpt;
      rsp_beat_type      own;
      bit                has_ready;
      bit                has_own;
      bit                hit;
      bit                bad;
      int unsigned       ring;
      int unsigned       off;
      int unsigned       a;
      int                i;
      logic [SLOT_W-1:0] pos;
      logic [SLOT_W-1:0] nxt;
      has_ready = 1'b0;
      has_own   = 1'b0;
      ready_rpt = make_rsp(KIND_READY, '0, '0, '0, '0, 1'b0);
      own       = ready_rpt;
      if (b.func == FUNC_READ) begin
         a = 32'({b.rslot, b.roff});
         rsp_due.insert(rsp_due.size(),
                        make_rsp(KIND_READ, b.rslot, slot_fill[b.rslot],
                                 slot_frame[b.rslot], byte_mirror[a], 1'b1));
         return 1'b1;
      end
      if (b.first) begin
         ring = ring_len();
         hit  = 1'b0;
         pos  = '0;
         // highest matching slot wins
         for (i = 0; i < int'(ring); i++) begin
            if (slot_frame[i] == b.frame) begin
               hit = 1'b1;
               pos = SLOT_W'(i);
            end
         end
         if (!hit && (b.frame > newest_frame_no || (b.frame == 1 && newest_frame_no != 1))) begin
            nxt = SLOT_W'((32'(newest_slot_no) + 1) % ring);
            if (slot_fill[nxt] != 0) begin
               has_ready = 1'b1;
               ready_rpt = make_rsp(KIND_READY, nxt, slot_fill[nxt], slot_frame[nxt], '0, 1'b0);
            end
            newest_frame_no = b.frame;
            newest_slot_no  = nxt;
            slot_fill[nxt]  = '0;
            slot_frame[nxt] = b.frame;
            hit = 1'b1;
            pos = nxt;
         end
         if (!hit) begin
            open_accepted = 1'b0;
            rsp_due.insert(rsp_due.size(), make_rsp(KIND_DROP, '0, '0, '0, '0, 1'b1));
            return 1'b1;
         end
         open_slot     = pos;
         open_accepted = 1'b1;
      end
      if (open_accepted) begin
         bad = (b.pkt == 0);
         off = 0;
         if (!bad) begin
            off = payload_len() * (32'(b.pkt) - 1) + 32'(b.idx);
            if (off >= FRAME_BYTES) bad = 1'b1;
         end
         if (bad) begin
            has_own = 1'b1;
            own = make_rsp(KIND_BEYOND, open_slot, slot_fill[open_slot], slot_frame[open_slot],
                           '0, 1'b1);
         end else begin
            a = 32'({open_slot, off[OFFSET_W-1:0]});
            if (!byte_mirror.exists(a)) written_addrs.insert(written_addrs.size(), a);
            byte_mirror[a] = b.data;
            if (off + 1 > 32'(slot_fill[open_slot])) slot_fill[open_slot] = SIZE_W'(off + 1);
         end
      end
      if (has_ready) begin
         ready_rpt.last = !has_own;
         rsp_due.insert(rsp_due.size(), ready_rpt);
      end
      if (has_own) rsp_due.insert(rsp_due.size(), own);
      return has_ready || has_own || open_accepted;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.func  = FUNC_STORE;
      b.frame = FRAME_W'($urandom);
      b.pkt   = PKT_W'($urandom);
      b.idx   = INDEX_W'($urandom);
      b.first = 1'($urandom_range(1));
      b.data  = BYTE_W'($urandom);
      b.rslot = RSLOT_W'($urandom);
      b.roff  = ROFF_W'($urandom);
      return b;
   endfunction

   task automatic push_beat(input req_beat_type b, output bit acted);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[FRAME_LSB +: FRAME_W] = b.frame;
      word[PKT_LSB +: PKT_W]     = b.pkt;
      word[INDEX_LSB +: INDEX_W] = b.idx;
      word[DATA_LSB +: BYTE_W]   = b.data;
      word[RSLOT_LSB +: RSLOT_W] = b.rslot;
      word[ROFF_LSB +: ROFF_W]   = b.roff;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= word;
      req_tuser  <= {b.first, b.func};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      acted = reassemble_beat(b);
   endtask

   task automatic store_beat(input logic [FRAME_W-1:0] frame, input logic [PKT_W-1:0] pkt,
                             input logic [INDEX_W-1:0] idx, input logic first,
                             input logic [BYTE_W-1:0] data);
      req_beat_type b;
      bit           acted;
      b       = random_beat();
      b.frame = frame;
      b.pkt   = pkt;
      b.idx   = idx;
      b.first = first;
      b.data  = data;
      push_beat(b, acted);
   endtask

   task automatic read_beat(input logic [RSLOT_W-1:0] slot, input logic [ROFF_W-1:0] off);
      req_beat_type b;
      bit           acted;
      b       = random_beat();
      b.func  = FUNC_READ;
      b.rslot = slot;
      b.roff  = off;
      push_beat(b, acted);
   endtask

   // waits until every predicted beat is back and the pipeline has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      want = (addr == CSR_PAYLOAD) ? 32'(value[PAYLOAD_W-1:0]) : 32'(value[RING_W-1:0]);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == CSR_PAYLOAD) payload_cfg = value[PAYLOAD_W-1:0];
      else ring_cfg = value[RING_W-1:0];
      // read back through a second transfer
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         flag_mismatch($sformatf("csr 0x%0h read 0x%0h, want 0x%0h", addr, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_rsp_beat();
      rsp_beat_type want;
      if (rsp_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected beat, kind %0d", rsp_tuser));
      end else begin
         want = rsp_due.pop_front();
         if (rsp_tuser != want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
         if (rsp_tdata[RSP_SLOT_LSB +: RSLOT_W] != want.slot)
            flag_mismatch($sformatf("slot %0d, want %0d",
                                    rsp_tdata[RSP_SLOT_LSB +: RSLOT_W], want.slot));
         if (rsp_tdata[RSP_SIZE_LSB +: SIZE_W] != want.size)
            flag_mismatch($sformatf("size %0d, want %0d",
                                    rsp_tdata[RSP_SIZE_LSB +: SIZE_W], want.size));
         if (rsp_tdata[RSP_TAG_LSB +: FRAME_W] != want.tag)
            flag_mismatch($sformatf("tag %0d, want %0d",
                                    rsp_tdata[RSP_TAG_LSB +: FRAME_W], want.tag));
         if (rsp_tdata[RSP_BYTE_LSB +: BYTE_W] != want.rbyte)
            flag_mismatch($sformatf("byte 0x%0h, want 0x%0h",
                                    rsp_tdata[RSP_BYTE_LSB +: BYTE_W], want.rbyte));
         if (rsp_tlast != want.last)
            flag_mismatch($sformatf("tlast %0b, want %0b", rsp_tlast, want.last));
      end
   endtask

   // response side: check the beat taken at this edge, then choose next tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_rsp_beat();
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic random_traffic(input int unsigned n_items);
      req_beat_type       b;
      int unsigned        done;
      int unsigned        roll;
      int unsigned        nbytes;
      int unsigned        pay;
      int unsigned        pick;
      int unsigned        a;
      int unsigned        k;
      logic [FRAME_W-1:0] frame_cur;
      logic [PKT_W-1:0]   pkt_cur;
      bit                 acted;
      done      = 0;
      frame_cur = newest_frame_no;
      pkt_cur   = PKT_W'(1);
      while (done < n_items) begin
         roll = $urandom_range(99);
         pay  = payload_len();
         b    = random_beat();
         if (roll < 65) begin
            if ($urandom_range(3) == 0) begin
               // next frame: mostly newer, now and then a restart, a big jump
               // or a frame still held in the ring
               pick = $urandom_range(9);
               if (pick == 0) frame_cur = FRAME_W'(1);
               else if (pick == 1) frame_cur = slot_frame[$urandom_range(ring_len() - 1)];
               else if (pick == 2) frame_cur = newest_frame_no + FRAME_W'($urandom_range(2000));
               else frame_cur = newest_frame_no + FRAME_W'($urandom_range(1, 3));
               pkt_cur = PKT_W'(1);
            end
            nbytes = $urandom_range(1, pay < 6 ? pay : 6);
            for (k = 0; k < nbytes; k++) begin
               b       = random_beat();
               b.frame = frame_cur;
               b.pkt   = pkt_cur;
               b.idx   = INDEX_W'(k);
               b.first = (k == 0);
               if (k != 0 && k == nbytes - 1 && $urandom_range(9) == 0)
                  b.idx = INDEX_W'($urandom);
               push_beat(b, acted);
               done += 32'(acted);
            end
            pkt_cur++;
            if ($urandom_range(7) == 0) pkt_cur = PKT_W'($urandom_range(1, 80));
         end else if (roll < 78) begin
            if (written_addrs.size() != 0) begin
               a       = written_addrs[$urandom_range(written_addrs.size() - 1)];
               b.func  = FUNC_READ;
               b.rslot = a[OFFSET_W +: RSLOT_W];
               b.roff  = a[ROFF_W-1:0];
               push_beat(b, acted);
               done += 32'(acted);
            end
         end else if (roll < 90) begin
            // packet of an older frame, with a tail of bytes
            b.frame = newest_frame_no - FRAME_W'($urandom_range(1, 40));
            b.first = 1'b1;
            push_beat(b, acted);
            done += 32'(acted);
            nbytes = $urandom_range(1, 2);
            for (k = 0; k < nbytes; k++) begin
               b.first = 1'b0;
               b.idx   = INDEX_W'(k + 1);
               b.data  = BYTE_W'($urandom);
               push_beat(b, acted);
               done += 32'(acted);
            end
         end else begin
            push_beat(b, acted);
            done += 32'(acted);
         end
      end
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      store_beat(16'd9, 13'd1, 10'd0, 1'b0, 8'h11);       // body byte before any packet
      store_beat(16'd0, 13'd1, 10'd0, 1'b1, 8'hA5);       // frame 0 hits reset tags
      store_beat(16'd0, 13'd1, 10'd1, 1'b0, 8'h5A);
      read_beat(2'd3, 16'd0);
      store_beat(16'd5, 13'd1, 10'd0, 1'b1, 8'hFF);
      store_beat(16'd5, 13'd64, 10'd1023, 1'b0, 8'h00);   // last byte of the slot
      store_beat(16'd5, 13'd65, 10'd0, 1'b0, 8'h3C);      // one past the slot
      store_beat(16'd5, 13'd0, 10'd0, 1'b0, 8'hC3);       // packet number zero
      store_beat(16'd5, 13'h1FFF, 10'd1023, 1'b0, 8'hFF);
      store_beat(16'd3, 13'd1, 10'd0, 1'b1, 8'h77);       // older frame, dropped
      store_beat(16'd3, 13'd1, 10'd1, 1'b0, 8'h78);
      store_beat(16'hFFFF, 13'd1, 10'd0, 1'b1, 8'h01);
      store_beat(16'd1, 13'd1, 10'd0, 1'b1, 8'h02);       // restart evicts a filled slot
      store_beat(16'd1, 13'd2, 10'd0, 1'b1, 8'h03);
      store_beat(16'd1, 13'd1, 10'd0, 1'b1, 8'h04);
      store_beat(16'd2, 13'd1, 10'd0, 1'b1, 8'h05);
      store_beat(16'd7, 13'd0, 10'd0, 1'b1, 8'h06);       // frame ready and beyond together
      read_beat(2'd1, 16'hFFFF);
      read_beat(2'd3, 16'd1024);
      read_beat(2'd1, 16'd0);
   endtask

   task automatic test_register_limits();
      settle();
      write_reg(CSR_PAYLOAD, 32'd0);
      write_reg(CSR_SLOTS, 32'd0);
      store_beat(16'd8, 13'd3, 10'd5, 1'b1, 8'h81);       // index past a one-byte payload
      store_beat(16'd8, 13'd4096, 10'd1023, 1'b0, 8'h82);
      read_beat(2'd0, 16'd7);
      store_beat(16'd9, 13'd1, 10'd0, 1'b1, 8'h83);
      settle();
      write_reg(CSR_PAYLOAD, 32'h7FF);
      write_reg(CSR_SLOTS, 32'd7);
      store_beat(16'd10, 13'd64, 10'd1023, 1'b1, 8'h84);  // payload clamps to the maximum
      store_beat(16'd10, 13'd2, 10'd3, 1'b0, 8'h85);
      read_beat(2'd1, 16'hFFFF);
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(CSR_PAYLOAD, 32'd3);
      write_reg(CSR_SLOTS, 32'd3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      random_traffic(80);
      // sender stays quiet until the backlog has fully drained
      settle();
   endtask

   task automatic test_random_traffic(input int unsigned payload, input int unsigned slots,
                                      input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned n_items);
      settle();
      write_reg(CSR_PAYLOAD, payload);
      write_reg(CSR_SLOTS, slots);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      random_traffic(n_items);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_limits();
      test_backpressure();
      test_random_traffic(12, 4, 28, 67, 320);
      test_random_traffic(2047, 7, 67, 28, 320);
      test_random_traffic(1, 2, 0, 0, 320);
      settle();
      if (mismatch_count == 0) $display("[frame_reassembly_ring] OK");
      else $display("[frame_reassembly_ring] ERROR");
      $finish;
   end

endmodule
